// ----- hdl/dttfp_pkg.sv -----
`default_nettype none
package dttfp_pkg;

	// Number of fraction digits kept; the result is the value times ten to this power.
	localparam int FRAC_DIGITS = 8;

	function automatic logic [63:0] pow10(input int n);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < n && i < 19; i++) begin
			r = r * 64'd10;
		end
		return r;
	endfunction

	localparam logic [63:0] VAL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SCALE      = pow10(FRAC_DIGITS);
	localparam logic [63:0] WHOLE_MAX  = VAL_MAX / SCALE;
	localparam logic [63:0] WHOLE_CAP  = WHOLE_MAX + 64'd1;
	localparam int          WHOLE_W    = $clog2(WHOLE_CAP + 64'd1);
	localparam int          FRAC_W     = $clog2(SCALE);
	localparam int          COUNT_W    = $clog2(FRAC_DIGITS + 1);
	localparam int          VALUE_W    = 63;

	// The saturated whole part, already scaled.
	localparam logic [63:0] CAP_SCALED = WHOLE_CAP * SCALE;

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharPoint = 8'h2E;

	typedef struct packed {
		logic                 err_seen;
		logic                 any_seen;
		logic [WHOLE_W-1:0]   whole_acc;
		logic [63:0]          whole_scaled;
		logic [FRAC_W-1:0]    frac_scaled;
	} acc_state_t;

	// Place value of the fraction digit that arrives at position k (counted from 0).
	function automatic logic [FRAC_W-1:0] place_value(input logic [COUNT_W-1:0] k);
		logic [FRAC_W-1:0] r;
		r = '0;
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (k == COUNT_W'(i)) begin
				r = FRAC_W'(pow10(FRAC_DIGITS - 1 - i));
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/dttfp_accum.sv -----
`default_nettype none
module dttfp_accum (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step,
	input  wire logic [7:0]              ch,
	input  wire logic                    end_marker,
	output dttfp_pkg::acc_state_t        acc
);

	logic                               err_q;
	logic                               any_q;
	logic                               point_q;
	logic [dttfp_pkg::COUNT_W-1:0]      count_q;
	logic [dttfp_pkg::WHOLE_W-1:0]      whole_q;
	logic [63:0]                        whole_scaled_q;
	logic [dttfp_pkg::FRAC_W-1:0]       frac_q;

	logic                               is_digit;
	logic [3:0]                         digit;
	logic [dttfp_pkg::WHOLE_W+3:0]      whole_grown;
	logic [63:0]                        scaled_grown;
	logic [dttfp_pkg::FRAC_W+3:0]       frac_add;

	assign is_digit = (ch >= dttfp_pkg::CharZero) && (ch <= dttfp_pkg::CharNine);
	assign digit    = 4'(ch - dttfp_pkg::CharZero);

	always_comb begin
		whole_grown  = ((dttfp_pkg::WHOLE_W+4)'(whole_q) << 3)
			+ ((dttfp_pkg::WHOLE_W+4)'(whole_q) << 1)
			+ (dttfp_pkg::WHOLE_W+4)'(digit);
		// Only used below the cap, where the scaled value is known to fit in 64 bits.
		scaled_grown = (whole_scaled_q << 3) + (whole_scaled_q << 1)
			+ 64'(digit) * dttfp_pkg::SCALE;
		frac_add     = (dttfp_pkg::FRAC_W+4)'(digit)
			* (dttfp_pkg::FRAC_W+4)'(dttfp_pkg::place_value(count_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q          <= 1'b0;
			any_q          <= 1'b0;
			point_q        <= 1'b0;
			count_q        <= '0;
			whole_q        <= '0;
			whole_scaled_q <= '0;
			frac_q         <= '0;
		end else if (step) begin
			if (end_marker) begin
				err_q          <= 1'b0;
				any_q          <= 1'b0;
				point_q        <= 1'b0;
				count_q        <= '0;
				whole_q        <= '0;
				whole_scaled_q <= '0;
				frac_q         <= '0;
			end else begin
				any_q <= 1'b1;
				if (!err_q) begin
					if (!point_q) begin
						if (ch == dttfp_pkg::CharPoint) begin
							point_q <= 1'b1;
						end else if (is_digit) begin
							if (whole_grown > (dttfp_pkg::WHOLE_W+4)'(dttfp_pkg::WHOLE_CAP)) begin
								whole_q        <= dttfp_pkg::WHOLE_W'(dttfp_pkg::WHOLE_CAP);
								whole_scaled_q <= dttfp_pkg::CAP_SCALED;
							end else begin
								whole_q        <= dttfp_pkg::WHOLE_W'(whole_grown);
								whole_scaled_q <= scaled_grown;
							end
						end else begin
							err_q <= 1'b1;
						end
					end else if (count_q < dttfp_pkg::COUNT_W'(dttfp_pkg::FRAC_DIGITS)) begin
						if (is_digit) begin
							frac_q  <= frac_q + dttfp_pkg::FRAC_W'(frac_add);
							count_q <= count_q + dttfp_pkg::COUNT_W'(1);
						end else begin
							err_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	assign acc.err_seen     = err_q;
	assign acc.any_seen     = any_q;
	assign acc.whole_acc    = whole_q;
	assign acc.whole_scaled = whole_scaled_q;
	assign acc.frac_scaled  = frac_q;

endmodule
`default_nettype wire

// ----- hdl/dttfp_result.sv -----
`default_nettype none
module dttfp_result (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire dttfp_pkg::acc_state_t             acc,
	output logic                                   slot_free,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic [dttfp_pkg::VALUE_W-1:0]          value,
	output logic                                   bad_text
);

	logic                               valid_q;
	logic [dttfp_pkg::VALUE_W-1:0]      value_q;
	logic                               bad_q;
	logic [63:0]                        sum;
	logic                               bad;

	always_comb begin
		sum = acc.whole_scaled + 64'(acc.frac_scaled);
		bad = acc.err_seen || !acc.any_seen
			|| (64'(acc.whole_acc) > dttfp_pkg::WHOLE_MAX)
			|| (sum > dttfp_pkg::VAL_MAX);
	end

	assign slot_free = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= bad ? '0 : sum[dttfp_pkg::VALUE_W-1:0];
			bad_q   <= bad;
		end
	end

	assign result_valid = valid_q;
	assign value        = value_q;
	assign bad_text     = bad_q;

endmodule
`default_nettype wire

// ----- hdl/decimal_text_to_fixed_point.sv -----
// Streaming ASCII decimal to fixed-point converter.
// The item channel (item_valid, item_ready, ch, end_marker) carries one
// character per transaction; a transaction with end_marker set ends the
// number and carries no character. The result channel (result_valid,
// result_ready, value, bad_text) gives one transaction for each end marker:
// the number times ten to the eighth, or bad_text set and value zero.
// One item per cycle is accepted while no end marker waits for the result
// register. Each item is held in the input register and is folded into the
// accumulators as it leaves it; an end marker loads the result register as it leaves.
// The accumulators keep the whole part both raw and pre-scaled, so the
// final value is one 64-bit add and compare.
// When the receiver stalls, characters keep flowing into the accumulators;
// only a further end marker waits in the input register until the result
// register is taken, and item_ready falls while it waits.
// Reset clears the accumulators and both valid flags, so the block starts
// on a fresh number with no result pending.
`default_nettype none
module decimal_text_to_fixed_point (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [7:0]                   ch,
	input  wire logic                         end_marker,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic [dttfp_pkg::VALUE_W-1:0]     value,
	output logic                              bad_text
);

	logic                    valid_s1;
	logic [7:0]              ch_s1;
	logic                    end_s1;
	logic                    go;
	logic                    slot_free;
	dttfp_pkg::acc_state_t   acc;

	assign go         = valid_s1 && (!end_s1 || slot_free);
	assign item_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			ch_s1  <= ch;
			end_s1 <= end_marker;
		end
	end

	dttfp_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go),
		.ch         (ch_s1),
		.end_marker (end_s1),
		.acc        (acc)
	);

	dttfp_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (go && end_s1),
		.acc          (acc),
		.slot_free    (slot_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.bad_text     (bad_text)
	);

endmodule
`default_nettype wire

// ----- dv/tb_decimal_text_to_fixed_point.sv -----
module tb_decimal_text_to_fixed_point;

	localparam logic [7:0] CharMinus = 8'h2D;
	localparam int IdlePercent = 28;
	localparam int DrainCycles = 6;

	typedef struct packed {
		logic [dttfp_pkg::VALUE_W-1:0] value;
		logic                          bad_text;
	} number_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic [7:0] ch = 8'h00;
	logic end_marker = 1'b0;
	logic result_ready = 1'b0;
	logic item_ready;
	logic result_valid;
	logic [dttfp_pkg::VALUE_W-1:0] value;
	logic bad_text;

	// Running parse of the current number, as the block should hold it.
	logic [dttfp_pkg::WHOLE_W-1:0] text_whole = '0;
	logic [dttfp_pkg::FRAC_W-1:0] text_frac = '0;
	logic [dttfp_pkg::COUNT_W-1:0] text_frac_digits = '0;
	bit text_point = 1'b0;
	bit text_started = 1'b0;
	bit text_broken = 1'b0;

	number_result_t expected_numbers[$];
	int errors = 0;
	int items_sent = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	decimal_text_to_fixed_point dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.ch(ch),
		.end_marker(end_marker),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.value(value),
		.bad_text(bad_text)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void fold_char(input logic [7:0] c);
		logic [63:0] grown;
		text_started = 1'b1;
		if (text_broken) begin
			return;
		end
		if (!text_point) begin
			if (c == dttfp_pkg::CharPoint) begin
				text_point = 1'b1;
			end else if (c >= dttfp_pkg::CharZero && c <= dttfp_pkg::CharNine) begin
				grown = 64'(text_whole) * 64'd10 + 64'(c - dttfp_pkg::CharZero);
				if (grown > dttfp_pkg::WHOLE_CAP) begin
					grown = dttfp_pkg::WHOLE_CAP;
				end
				text_whole = grown[dttfp_pkg::WHOLE_W-1:0];
			end else begin
				text_broken = 1'b1;
			end
		end else if (text_frac_digits < dttfp_pkg::COUNT_W'(dttfp_pkg::FRAC_DIGITS)) begin
			// Anything past the last kept fraction digit is not looked at.
			if (c >= dttfp_pkg::CharZero && c <= dttfp_pkg::CharNine) begin
				text_frac = dttfp_pkg::FRAC_W'(64'(text_frac) * 64'd10
					+ 64'(c - dttfp_pkg::CharZero));
				text_frac_digits = text_frac_digits + dttfp_pkg::COUNT_W'(1);
			end else begin
				text_broken = 1'b1;
			end
		end
	endfunction

	function automatic number_result_t finish_number();
		number_result_t r;
		logic [63:0] frac;
		logic [63:0] total;
		bit bad;
		bad = text_broken || !text_started;
		total = '0;
		if (!bad) begin
			frac = 64'(text_frac);
			for (int i = int'(text_frac_digits); i < dttfp_pkg::FRAC_DIGITS; i++) begin
				frac = frac * 64'd10;
			end
			if (64'(text_whole) > dttfp_pkg::WHOLE_MAX) begin
				bad = 1'b1;
			end else begin
				total = 64'(text_whole) * dttfp_pkg::SCALE + frac;
				if (total > dttfp_pkg::VAL_MAX) begin
					bad = 1'b1;
				end
			end
		end
		r.value = bad ? '0 : total[dttfp_pkg::VALUE_W-1:0];
		r.bad_text = bad;
		text_whole = '0;
		text_frac = '0;
		text_frac_digits = '0;
		text_point = 1'b0;
		text_started = 1'b0;
		text_broken = 1'b0;
		return r;
	endfunction

	// Both handshakes are sampled here, before the block's own updates land.
	always @(posedge clk) begin : number_checker
		number_result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_numbers.size() == 0) begin
					$display("%0t: result with none expected: value %0d bad_text %0b",
						$time, value, bad_text);
					errors++;
				end else begin
					want = expected_numbers.pop_front();
					if (value !== want.value) begin
						$display("%0t: value mismatch: expected %0d actual %0d",
							$time, want.value, value);
						errors++;
					end
					if (bad_text !== want.bad_text) begin
						$display("%0t: bad_text mismatch: expected %0b actual %0b",
							$time, want.bad_text, bad_text);
						errors++;
					end
				end
			end
			if (item_valid && item_ready) begin
				if (end_marker) begin
					expected_numbers.push_back(finish_number());
				end else begin
					fold_char(ch);
				end
			end
		end
	end

	always @(negedge clk) begin
		result_ready <= arst_n && !(rx_idle_en && $urandom_range(99) < IdlePercent);
	end

	task automatic send_item(input logic [7:0] c, input logic e);
		@(negedge clk);
		while (tx_idle_en && $urandom_range(99) < IdlePercent) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		ch <= c;
		end_marker <= e;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	task automatic send_number(input logic [7:0] text[$]);
		foreach (text[i]) begin
			send_item(text[i], 1'b0);
		end
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_string(input string s);
		logic [7:0] text[$];
		for (int i = 0; i < s.len(); i++) begin
			text.push_back(s[i]);
		end
		send_number(text);
	endtask

	// Lowers valid, then waits until every outstanding number has come back.
	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_numbers.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic push_digits(ref logic [7:0] text[$], input int count);
		for (int i = 0; i < count; i++) begin
			text.push_back(dttfp_pkg::CharZero + 8'($urandom_range(9)));
		end
	endtask

	task automatic random_numbers(input int item_count);
		logic [7:0] text[$];
		string top;
		int goal;
		int kind;
		int idx;
		goal = items_sent + item_count;
		while (items_sent < goal) begin
			text = {};
			kind = $urandom_range(99);
			if (kind < 10) begin
				// Around the top of the range: the two digits after 547758 decide overflow.
				case ($urandom_range(2))
					0: top = "92233720368";
					1: top = "92233720369";
					default: top = "9223372036";
				endcase
				for (int i = 0; i < top.len(); i++) begin
					text.push_back(top[i]);
				end
				text.push_back(dttfp_pkg::CharPoint);
				top = "547758";
				for (int i = 0; i < top.len(); i++) begin
					text.push_back(top[i]);
				end
				push_digits(text, $urandom_range(2, 4));
			end else if (kind < 20) begin
				repeat ($urandom_range(6)) begin
					if ($urandom_range(1) == 0) begin
						text.push_back(8'($urandom_range(255)));
					end else if ($urandom_range(3) == 0) begin
						text.push_back($urandom_range(1) ? CharMinus : dttfp_pkg::CharPoint);
					end else begin
						push_digits(text, 1);
					end
				end
			end else begin
				push_digits(text, ($urandom_range(99) < 10) ? $urandom_range(13, 20)
					: $urandom_range(0, 9));
				if ($urandom_range(3) != 0) begin
					text.push_back(dttfp_pkg::CharPoint);
					push_digits(text, $urandom_range(0, dttfp_pkg::FRAC_DIGITS));
					repeat ($urandom_range(3)) begin
						text.push_back(8'($urandom_range(255)));
					end
				end
				if (kind < 35 && text.size() > 0) begin
					idx = $urandom_range(text.size() - 1);
					case ($urandom_range(2))
						0: text[idx] = CharMinus;
						1: text[idx] = dttfp_pkg::CharPoint;
						default: text[idx] = 8'($urandom_range(255));
					endcase
				end
			end
			send_number(text);
		end
	endtask

	task automatic test_empty_text();
		send_item(8'h35, 1'b1);
	endtask

	task automatic test_lone_point();
		send_string(".");
	endtask

	task automatic test_minus_sign();
		send_string("-");
		send_string(".-");
	endtask

	task automatic test_second_point();
		send_string("..");
	endtask

	task automatic test_bad_bytes();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);
	endtask

	task automatic test_excess_fraction();
		send_string(".00000001Z");
	endtask

	task automatic test_pause_until_drained();
		random_numbers(60);
		drain_results();
		random_numbers(60);
	endtask

	task automatic test_without_idling();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		random_numbers(300);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_text();
		test_lone_point();
		test_minus_sign();
		test_second_point();
		test_bad_bytes();
		test_excess_fraction();
		random_numbers(700);
		test_pause_until_drained();
		test_without_idling();
		random_numbers(600);
		drain_results();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
